@@ rtl/altitude_complementary_filter_unit_defines.svh @@
// Assertion macros for the altitude filter RTL.
`ifndef ALTITUDE_COMPLEMENTARY_FILTER_UNIT_DEFINES_SVH
`define ALTITUDE_COMPLEMENTARY_FILTER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// General property, checked on every rising edge outside reset.
`define ACF_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ACF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ACF_ASSERT(label, clk, rstn, prop, msg)
`define ACF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

@@ rtl/acf_pkg.sv @@
// Shared types, widths and constants of the altitude complementary filter.
`default_nettype none

package acf_pkg;

    // Operand and result widths of the serial multiply and round unit.
    localparam int A_W       = 34;            // signed multiplicand
    localparam int B_W       = 20;            // unsigned multiplier, one bit per cycle
    localparam int P_W       = A_W + B_W;     // full product
    localparam int N_W       = P_W + 1;       // product plus rounding offset
    localparam int SH_LO     = 12;
    localparam int SH_HI     = 16;
    localparam int Q_W       = N_W - SH_LO;   // widest rounded result
    localparam int SUM_W     = Q_W + 1;       // state value plus result
    localparam int REM_W     = 20;            // divisors are below 2^20
    localparam int DIV_PRE   = 19;            // leading dividend bits that never exceed a divisor
    localparam int DIV_ITER  = N_W - DIV_PRE; // quotient bits produced serially
    localparam int MUL_CNT_W = $clog2(B_W);
    localparam int DIV_CNT_W = $clog2(DIV_ITER);

    // Field widths.
    localparam int STATE_W     = 32;
    localparam int GAIN_W      = 16;
    localparam int ACCEL_W     = 16;
    localparam int DT_W        = 17;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 64;

    // Physical constants and limits.
    localparam logic [B_W-1:0]     GRAVITY_Q16   = B_W'(642689);
    localparam logic [STATE_W-1:0] DT_MAX_US     = STATE_W'(100000);
    localparam logic [DT_W-1:0]    DT_DEFAULT_US = DT_W'(10000);
    localparam logic [REM_W-1:0]   DIV_US_PER_S  = REM_W'(1000000);
    localparam logic [REM_W-1:0]   DIV_BARO_VEL  = REM_W'(655360);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ACCEL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BARO  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GPS   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BARO_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GPS_GAIN  = 2'd2;

    // Rounding applied after the multiply.
    typedef enum logic [1:0] {
        RND_SH12,
        RND_SH16,
        RND_DIV_US,
        RND_DIV_BARO
    } t_rnd_mode;

    typedef enum logic [2:0] {
        MDU_IDLE,
        MDU_MUL,
        MDU_RND,
        MDU_DIV,
        MDU_FIX,
        MDU_DONE
    } t_mdu_state;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_ALT,
        ST_VEL,
        ST_BALT,
        ST_BVEL,
        ST_BBIAS,
        ST_GPS,
        ST_DONE
    } t_acf_state;

    // Request to the multiply and round unit.
    typedef struct packed {
        logic                   start;
        t_rnd_mode              mode;
        logic signed [A_W-1:0]  a;
        logic        [B_W-1:0]  b;
    } t_mdu_req;

    // Response from the multiply and round unit.
    typedef struct packed {
        logic                   done;
        logic signed [Q_W-1:0]  q;
    } t_mdu_rsp;

    // Clamp a widened sum to the signed 32-bit range.
    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [STATE_W-1:0] res;
        if (x[SUM_W-1:STATE_W-1] == {(SUM_W-STATE_W+1){x[SUM_W-1]}}) begin
            res = x[STATE_W-1:0];
        end else if (x[SUM_W-1]) begin
            res = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(STATE_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/acf_mdu.sv @@
// Serial multiply and round unit: one multiplier bit, then one quotient bit per cycle.
`default_nettype none

module acf_mdu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire acf_pkg::t_mdu_req i_req,
    output acf_pkg::t_mdu_rsp      o_rsp
);
    import acf_pkg::*;

    t_mdu_state                r_state;
    t_mdu_state                n_state;
    t_rnd_mode                 r_mode;
    logic signed [A_W-1:0]     r_a;
    logic        [B_W-1:0]     r_b;
    logic signed [P_W-1:0]     r_acc;
    logic [MUL_CNT_W-1:0]      r_mul_cnt;
    logic [DIV_CNT_W-1:0]      r_div_cnt;
    logic                      r_neg;
    logic [REM_W-1:0]          r_rem;
    logic [DIV_ITER-1:0]       r_dvd;
    logic signed [Q_W-1:0]     r_q;

    logic signed [P_W-1:0]     w_addend;
    logic signed [P_W-1:0]     w_acc_next;
    logic signed [N_W-1:0]     w_half;
    logic signed [N_W-1:0]     w_n;
    logic        [N_W-1:0]     w_mag;
    logic        [REM_W-1:0]   w_divisor;
    logic        [REM_W:0]     w_part;
    logic        [REM_W:0]     w_diff;
    logic                      w_ge;
    logic signed [Q_W-1:0]     w_q_sh12;
    logic signed [Q_W-1:0]     w_q_sh16;
    logic        [Q_W-1:0]     w_qmag;
    logic signed [Q_W-1:0]     w_q_fix;

    // Shift-and-add step, multiplier taken MSB first.
    assign w_addend   = r_b[B_W-1] ? {{(P_W-A_W){r_a[A_W-1]}}, r_a} : '0;
    assign w_acc_next = (r_acc <<< 1) + w_addend;

    // Rounding offset and divisor by mode.
    always_comb begin
        case (r_mode)
            RND_SH12: begin
                w_half    = N_W'(2048);
                w_divisor = DIV_US_PER_S;
            end
            RND_SH16: begin
                w_half    = N_W'(32768);
                w_divisor = DIV_US_PER_S;
            end
            RND_DIV_US: begin
                w_half    = N_W'(500000);
                w_divisor = DIV_US_PER_S;
            end
            RND_DIV_BARO: begin
                w_half    = N_W'(327680);
                w_divisor = DIV_BARO_VEL;
            end
            default: begin
                w_half    = '0;
                w_divisor = DIV_US_PER_S;
            end
        endcase
    end

    // Offset product and its magnitude for the floor division.
    assign w_n   = $signed({r_acc[P_W-1], r_acc}) + w_half;
    assign w_mag = w_n[N_W-1] ? N_W'(-w_n) : w_n;

    // Power-of-two rounding is an arithmetic shift.
    assign w_q_sh12 = w_n[N_W-1:SH_LO];
    assign w_q_sh16 = {{(SH_HI-SH_LO){w_n[N_W-1]}}, w_n[N_W-1:SH_HI]};

    // Restoring division step.
    assign w_part = {r_rem, r_dvd[DIV_ITER-1]};
    assign w_ge   = (w_part >= {1'b0, w_divisor});
    assign w_diff = w_part - {1'b0, w_divisor};

    // Floor of a negative dividend rounds the magnitude up when a remainder is left.
    assign w_qmag  = {{(Q_W-DIV_ITER){1'b0}}, r_dvd};
    assign w_q_fix = r_neg ? $signed(-(w_qmag + Q_W'(r_rem != '0))) : $signed(w_qmag);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            MDU_IDLE: begin
                if (i_req.start) begin
                    n_state = MDU_MUL;
                end
            end
            MDU_MUL: begin
                if (r_mul_cnt == MUL_CNT_W'(B_W - 1)) begin
                    n_state = MDU_RND;
                end
            end
            MDU_RND: begin
                if (r_mode == RND_SH12 || r_mode == RND_SH16) begin
                    n_state = MDU_DONE;
                end else begin
                    n_state = MDU_DIV;
                end
            end
            MDU_DIV: begin
                if (r_div_cnt == DIV_CNT_W'(DIV_ITER - 1)) begin
                    n_state = MDU_FIX;
                end
            end
            MDU_FIX:  n_state = MDU_DONE;
            MDU_DONE: n_state = MDU_IDLE;
            default:  n_state = MDU_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_rsp.done = (r_state == MDU_DONE);
        o_rsp.q    = r_q;
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MDU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            MDU_IDLE: begin
                if (i_req.start) begin
                    r_a       <= i_req.a;
                    r_b       <= i_req.b;
                    r_mode    <= i_req.mode;
                    r_acc     <= '0;
                    r_mul_cnt <= '0;
                end
            end
            MDU_MUL: begin
                r_acc     <= w_acc_next;
                r_b       <= {r_b[B_W-2:0], 1'b0};
                r_mul_cnt <= r_mul_cnt + 1'b1;
            end
            MDU_RND: begin
                if (r_mode == RND_SH12) begin
                    r_q <= w_q_sh12;
                end else if (r_mode == RND_SH16) begin
                    r_q <= w_q_sh16;
                end else begin
                    r_neg     <= w_n[N_W-1];
                    r_rem     <= {{(REM_W-DIV_PRE){1'b0}}, w_mag[N_W-1 -: DIV_PRE]};
                    r_dvd     <= w_mag[DIV_ITER-1:0];
                    r_div_cnt <= '0;
                end
            end
            MDU_DIV: begin
                r_rem     <= w_ge ? w_diff[REM_W-1:0] : w_part[REM_W-1:0];
                r_dvd     <= {r_dvd[DIV_ITER-2:0], w_ge};
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            MDU_FIX: begin
                r_q <= w_q_fix;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/altitude_complementary_filter_unit.sv @@
// Top level of the vertical complementary-filter altitude estimator.
`default_nettype none

// The estimator takes one word at a time and returns one result word per input word,
// carrying the altitude and vertical velocity after the update and the GPS anchor flag.
// Every product runs through a single serial multiply and round unit that handles one
// multiplier bit per cycle and, where a divide by 1000000 or 655360 is needed, one
// quotient bit per cycle. An accel word takes one shift-rounded and two divided products,
// a baro word two shift-rounded and one divided, a GPS word after anchoring one
// shift-rounded product, and the first GPS word or an unused command none. A finished
// result waits in an output register, so the next input word is taken while it is still
// unread. Gain registers may be written only while the block is idle.

`include "altitude_complementary_filter_unit_defines.svh"

module altitude_complementary_filter_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input stream.
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: accel_g [15:0], timestamp_us [47:16], measured_altitude [79:48]
    input  wire logic [acf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: command [1:0]
    input  wire logic [acf_pkg::CMD_W-1:0]         s_axis_tuser,
    // Result stream.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata: altitude_estimate [31:0], vertical_velocity [63:32]
    output logic [acf_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // tuser: altitude_anchored [0]
    output logic [0:0]                             m_axis_tuser,
    // Configuration write channel.
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [acf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [acf_pkg::GAIN_W-1:0]        i_cfg_data
);
    import acf_pkg::*;

    // Gains.
    logic [GAIN_W-1:0]           r_baro_gain;
    logic [GAIN_W-1:0]           r_bias_gain;
    logic [GAIN_W-1:0]           r_gps_gain;

    // Filter state.
    logic [STATE_W-1:0]          r_last_time;
    logic signed [STATE_W-1:0]   r_alt;
    logic signed [STATE_W-1:0]   r_vel;
    logic signed [STATE_W-1:0]   r_abias;
    logic signed [STATE_W-1:0]   r_bbias;
    logic                        r_anch;

    // Sequencer.
    t_acf_state                  r_state;
    t_acf_state                  n_state;
    logic                        r_go;
    logic                        n_go;

    // Per-item operands.
    logic signed [A_W-1:0]       r_opnd;
    logic signed [A_W-1:0]       r_lin;
    logic [DT_W-1:0]             r_dt;

    // Output register.
    logic                        r_out_valid;
    logic signed [STATE_W-1:0]   r_out_alt;
    logic signed [STATE_W-1:0]   r_out_vel;
    logic                        r_out_anch;

    t_mdu_req                    w_req;
    t_mdu_rsp                    w_rsp;

    logic                        w_in_acc;
    logic [CMD_W-1:0]            w_cmd;
    logic signed [ACCEL_W-1:0]   w_accel_g;
    logic [STATE_W-1:0]          w_ts;
    logic signed [STATE_W-1:0]   w_meas;
    logic [STATE_W-1:0]          w_elapsed;
    logic [DT_W-1:0]             w_dt;
    logic signed [A_W-1:0]       w_opnd;
    logic signed [SUM_W-1:0]     w_q_ext;
    logic signed [SUM_W-1:0]     w_lin_full;
    logic signed [STATE_W-1:0]   w_base;
    logic                        w_sub;
    logic signed [SUM_W-1:0]     w_sum;
    logic signed [STATE_W-1:0]   w_sat;
    logic                        w_out_load;

    // Input word unpacking.
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_cmd     = s_axis_tuser;
    assign w_accel_g = s_axis_tdata[15:0];
    assign w_ts      = s_axis_tdata[47:16];
    assign w_meas    = s_axis_tdata[79:48];

    // Elapsed time, replaced by the default when zero or too long.
    assign w_elapsed = w_ts - r_last_time;
    assign w_dt = (w_elapsed == '0 || w_elapsed > DT_MAX_US) ? DT_DEFAULT_US
                                                              : w_elapsed[DT_W-1:0];

    // Operand kept for the item: accel sample, baro error or GPS error.
    always_comb begin
        case (w_cmd)
            CMD_ACCEL: w_opnd = {{(A_W-ACCEL_W){w_accel_g[ACCEL_W-1]}}, w_accel_g};
            CMD_BARO:  w_opnd = {{(A_W-STATE_W){w_meas[STATE_W-1]}}, w_meas}
                              - {{(A_W-STATE_W){r_bbias[STATE_W-1]}}, r_bbias}
                              - {{(A_W-STATE_W){r_alt[STATE_W-1]}}, r_alt};
            CMD_GPS:   w_opnd = {{(A_W-STATE_W){w_meas[STATE_W-1]}}, w_meas}
                              - {{(A_W-STATE_W){r_alt[STATE_W-1]}}, r_alt};
            default:   w_opnd = '0;
        endcase
    end

    // Linear acceleration from the rounded product.
    assign w_q_ext    = {w_rsp.q[Q_W-1], w_rsp.q};
    assign w_lin_full = w_q_ext - SUM_W'(GRAVITY_Q16)
                        - {{(SUM_W-STATE_W){r_abias[STATE_W-1]}}, r_abias};

    // Saturating state update for the operation that just finished.
    always_comb begin
        case (r_state)
            ST_ALT, ST_BALT: begin
                w_base = r_alt;
                w_sub  = 1'b0;
            end
            ST_VEL, ST_BVEL: begin
                w_base = r_vel;
                w_sub  = 1'b0;
            end
            ST_BBIAS: begin
                w_base = r_abias;
                w_sub  = 1'b1;
            end
            ST_GPS: begin
                w_base = r_bbias;
                w_sub  = 1'b1;
            end
            default: begin
                w_base = r_alt;
                w_sub  = 1'b0;
            end
        endcase
    end

    assign w_sum = w_sub ? {{(SUM_W-STATE_W){w_base[STATE_W-1]}}, w_base} - w_q_ext
                         : {{(SUM_W-STATE_W){w_base[STATE_W-1]}}, w_base} + w_q_ext;
    assign w_sat = sat32(w_sum);

    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (w_cmd)
                        CMD_ACCEL: n_state = ST_ACC;
                        CMD_BARO:  n_state = ST_BALT;
                        CMD_GPS:   n_state = r_anch ? ST_GPS : ST_DONE;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_ACC:   if (w_rsp.done) n_state = ST_ALT;
            ST_ALT:   if (w_rsp.done) n_state = ST_VEL;
            ST_VEL:   if (w_rsp.done) n_state = ST_DONE;
            ST_BALT:  if (w_rsp.done) n_state = ST_BVEL;
            ST_BVEL:  if (w_rsp.done) n_state = ST_BBIAS;
            ST_BBIAS: if (w_rsp.done) n_state = ST_DONE;
            ST_GPS:   if (w_rsp.done) n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // Launch the unit once on entering an arithmetic step.
        n_go = (n_state != r_state) && (n_state != ST_IDLE) && (n_state != ST_DONE);
    end

    // Outputs and unit request.
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        o_cfg_ready   = 1'b1;
        m_axis_tvalid = r_out_valid;
        m_axis_tdata  = {r_out_vel, r_out_alt};
        m_axis_tuser  = r_out_anch;
        w_req.start   = r_go;
        w_req.mode    = RND_SH16;
        w_req.a       = r_opnd;
        w_req.b       = {{(B_W-GAIN_W){1'b0}}, r_baro_gain};
        case (r_state)
            ST_ACC: begin
                w_req.mode = RND_SH12;
                w_req.b    = GRAVITY_Q16;
            end
            ST_ALT: begin
                w_req.mode = RND_DIV_US;
                w_req.a    = {{(A_W-STATE_W){r_vel[STATE_W-1]}}, r_vel};
                w_req.b    = {{(B_W-DT_W){1'b0}}, r_dt};
            end
            ST_VEL: begin
                w_req.mode = RND_DIV_US;
                w_req.a    = r_lin;
                w_req.b    = {{(B_W-DT_W){1'b0}}, r_dt};
            end
            ST_BVEL: begin
                w_req.mode = RND_DIV_BARO;
            end
            ST_BBIAS: begin
                w_req.b = {{(B_W-GAIN_W){1'b0}}, r_bias_gain};
            end
            ST_GPS: begin
                w_req.b = {{(B_W-GAIN_W){1'b0}}, r_gps_gain};
            end
            default: begin
            end
        endcase
    end

    acf_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Sequencer, gains and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
            r_baro_gain <= '0;
            r_bias_gain <= '0;
            r_gps_gain  <= '0;
            r_last_time <= '0;
            r_alt       <= '0;
            r_vel       <= '0;
            r_abias     <= '0;
            r_bbias     <= '0;
            r_anch      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BARO_GAIN: r_baro_gain <= i_cfg_data;
                    CFG_BIAS_GAIN: r_bias_gain <= i_cfg_data;
                    CFG_GPS_GAIN:  r_gps_gain  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // Immediate updates on acceptance.
            if (w_in_acc) begin
                if (w_cmd == CMD_ACCEL) begin
                    r_last_time <= w_ts;
                end
                if (w_cmd == CMD_GPS && !r_anch) begin
                    r_alt   <= w_meas;
                    r_bbias <= '0;
                    r_anch  <= 1'b1;
                end
            end

            // Commit each finished product.
            if (w_rsp.done) begin
                case (r_state)
                    ST_ALT, ST_BALT: r_alt   <= w_sat;
                    ST_VEL, ST_BVEL: r_vel   <= w_sat;
                    ST_BBIAS:        r_abias <= w_sat;
                    ST_GPS:          r_bbias <= w_sat;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Operand and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_opnd <= w_opnd;
            r_dt   <= w_dt;
        end
        if (w_rsp.done && r_state == ST_ACC) begin
            r_lin <= w_lin_full[A_W-1:0];
        end
        if (w_out_load) begin
            r_out_alt  <= r_alt;
            r_out_vel  <= r_vel;
            r_out_anch <= r_anch;
        end
    end

    // Checks on the sequencing.
    `ACF_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
                     !s_axis_tready, "input word accepted while an item is in work")
    `ACF_ASSERT_NEXT(a_anchor_sticky, i_clk, i_rst_n, r_anch, r_anch,
                     "anchor flag cleared after GPS anchoring")
    `ACF_ASSERT(a_out_from_done, i_clk, i_rst_n,
                $rose(m_axis_tvalid) |-> $past(r_state == ST_DONE),
                "result word raised outside the done step")
    `ACF_ASSERT(a_done_in_step, i_clk, i_rst_n,
                w_rsp.done |-> (r_state != ST_IDLE && r_state != ST_DONE),
                "unit finished with no arithmetic step pending")

endmodule

`default_nettype wire

@@ verif/altitude_complementary_filter_unit_checker.sv @@
// Result checker for the altitude filter: tracks the estimate and compares every result word.
module altitude_complementary_filter_unit_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream as seen at the block.
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    // tdata: accel_g [15:0], timestamp_us [47:16], measured_altitude [79:48]
    input  logic [acf_pkg::IN_TDATA_W-1:0]    i_in_data,
    // tuser: command [1:0]
    input  logic [acf_pkg::CMD_W-1:0]         i_in_user,
    // Result stream as seen at the block.
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    // tdata: altitude_estimate [31:0], vertical_velocity [63:32]
    input  logic [acf_pkg::OUT_TDATA_W-1:0]   i_out_data,
    // tuser: altitude_anchored [0]
    input  logic [0:0]                        i_out_user,
    // Gain write channel.
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [acf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [acf_pkg::GAIN_W-1:0]        i_cfg_data,
    // Results still owed by the block, and failures seen so far.
    output int                                o_pending,
    output int                                o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import acf_pkg::*;

    localparam longint GRAVITY_MS2_Q16 = 642689;
    localparam longint DT_LIMIT_US     = 100000;
    localparam longint DT_FALLBACK_US  = 10000;
    localparam longint US_PER_SECOND   = 1000000;
    localparam longint Q16_ONE         = 65536;
    localparam longint BARO_VEL_DIV    = 655360;

    typedef struct packed {
        logic signed [31:0] altitude;
        logic signed [31:0] velocity;
        logic               anchored;
    } estimate_t;

    // Tracked copy of the filter state and its gains.
    logic [GAIN_W-1:0]  baro_gain;
    logic [GAIN_W-1:0]  bias_gain;
    logic [GAIN_W-1:0]  gps_gain;
    logic [31:0]        last_stamp_us;
    logic signed [31:0] est_altitude;
    logic signed [31:0] est_velocity;
    logic signed [31:0] accel_bias;
    logic signed [31:0] baro_bias;
    logic               is_anchored;

    estimate_t expected_estimates[$];
    int        fail_total = 0;

    // Divide with round to nearest, ties toward plus infinity.
    function automatic longint div_round(input longint num, input longint den);
        longint n;
        n = num + den / 2;
        if (n >= 0) begin
            return n / den;
        end
        return -((-n + den - 1) / den);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > longint'(32'sh7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end
        if (x < -longint'(32'sh7FFF_FFFF) - 1) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // Apply one input word to the tracked state and return the estimate it leaves.
    function automatic estimate_t advance_estimate(input logic [CMD_W-1:0] cmd,
                                                   input logic signed [15:0] accel_g,
                                                   input logic [31:0] stamp_us,
                                                   input logic signed [31:0] meas_alt);
        estimate_t res;
        logic [31:0] elapsed;
        longint dt_len;
        longint accel_q16;
        longint linear;
        longint err;
        longint gain_a;
        longint gain_b;
        logic signed [31:0] old_vel;
        case (cmd)
            CMD_ACCEL: begin
                elapsed = stamp_us - last_stamp_us;
                last_stamp_us = stamp_us;
                dt_len = elapsed;
                if (dt_len == 0 || dt_len > DT_LIMIT_US) begin
                    dt_len = DT_FALLBACK_US;
                end
                accel_q16 = div_round(longint'(accel_g) * 16 * GRAVITY_MS2_Q16, Q16_ONE);
                linear = accel_q16 - GRAVITY_MS2_Q16 - longint'(accel_bias);
                old_vel = est_velocity;
                // Position moves with the old speed, speed with the corrected accel.
                est_altitude = clamp32(longint'(est_altitude) +
                                       div_round(longint'(old_vel) * dt_len, US_PER_SECOND));
                est_velocity = clamp32(longint'(est_velocity) +
                                       div_round(linear * dt_len, US_PER_SECOND));
            end
            CMD_BARO: begin
                gain_a = baro_gain;
                gain_b = bias_gain;
                err = longint'(meas_alt) - longint'(baro_bias) - longint'(est_altitude);
                est_altitude = clamp32(longint'(est_altitude) + div_round(err * gain_a, Q16_ONE));
                est_velocity = clamp32(longint'(est_velocity) +
                                       div_round(err * gain_a, BARO_VEL_DIV));
                accel_bias = clamp32(longint'(accel_bias) - div_round(err * gain_b, Q16_ONE));
            end
            CMD_GPS: begin
                if (!is_anchored) begin
                    // The first fix sets the altitude outright.
                    est_altitude = meas_alt;
                    baro_bias = '0;
                    is_anchored = 1'b1;
                end else begin
                    gain_a = gps_gain;
                    err = longint'(meas_alt) - longint'(est_altitude);
                    baro_bias = clamp32(longint'(baro_bias) - div_round(err * gain_a, Q16_ONE));
                end
            end
            default: begin
                // The spare command leaves the state alone.
            end
        endcase
        res.altitude = est_altitude;
        res.velocity = est_velocity;
        res.anchored = is_anchored;
        return res;
    endfunction

    // Watch all three channels at each rising edge.
    always @(posedge i_clk) begin : track
        estimate_t want;
        estimate_t got;
        if (!i_rst_n) begin
            baro_gain = '0;
            bias_gain = '0;
            gps_gain = '0;
            last_stamp_us = '0;
            est_altitude = '0;
            est_velocity = '0;
            accel_bias = '0;
            baro_bias = '0;
            is_anchored = 1'b0;
            expected_estimates.delete();
        end else begin
            // Compare a delivered result word with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                got.altitude = i_out_data[31:0];
                got.velocity = i_out_data[63:32];
                got.anchored = i_out_user[0];
                if (expected_estimates.size() == 0) begin
                    $error("result word with no prediction waiting: altitude %0d velocity %0d",
                           got.altitude, got.velocity);
                    fail_total++;
                end else begin
                    want = expected_estimates.pop_front();
                    if (got.altitude !== want.altitude) begin
                        $error("altitude_estimate: expected %0d, actual %0d",
                               want.altitude, got.altitude);
                        fail_total++;
                    end
                    if (got.velocity !== want.velocity) begin
                        $error("vertical_velocity: expected %0d, actual %0d",
                               want.velocity, got.velocity);
                        fail_total++;
                    end
                    if (got.anchored !== want.anchored) begin
                        $error("altitude_anchored: expected %0d, actual %0d",
                               want.anchored, got.anchored);
                        fail_total++;
                    end
                end
            end
            // Predict the result of an accepted input word.
            if (i_in_valid && i_in_ready) begin
                expected_estimates.push_back(advance_estimate(i_in_user, i_in_data[15:0],
                                                              i_in_data[47:16],
                                                              i_in_data[79:48]));
            end
            // Follow gain writes; the spare index is ignored.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BARO_GAIN: baro_gain = i_cfg_data;
                    CFG_BIAS_GAIN: bias_gain = i_cfg_data;
                    CFG_GPS_GAIN:  gps_gain = i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        o_pending <= expected_estimates.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ verif/altitude_complementary_filter_unit_tb.sv @@
// Testbench top for the altitude filter: clock, reset, stimulus, result stalls and verdict.
module altitude_complementary_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import acf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;
    localparam int PHASES         = 7;
    localparam int PHASE_WORDS    = 204;
    localparam int TAIL_WORDS     = 150;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES   = 200;
    localparam int STALL_LIMIT    = 5000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_TDATA_W-1:0]    s_axis_tdata;
    logic [CMD_W-1:0]         s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;
    logic [0:0]               m_axis_tuser;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [GAIN_W-1:0]        i_cfg_data;

    int pending_results;
    int fail_count;

    // Stimulus controls shared with the result-side process.
    bit no_idle = 1'b0;
    bit hold_output = 1'b0;

    // Sensor scene the random words are drawn from.
    logic [31:0] sensor_clock_us;
    int          sensor_alt;

    altitude_complementary_filter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    altitude_complementary_filter_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending_results),
        .o_fail_count (fail_count)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result side: random ready bursts, one long hold on request.
    initial begin : result_sink
        int  burst;
        logic level;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                hold_output = 1'b0;
                level = 1'b0;
                burst = RX_HOLD_CYCLES;
            end else begin
                level = no_idle || ($urandom_range(0, 2) != 0);
                burst = $urandom_range(1, 10);
            end
            m_axis_tready <= level;
            repeat (burst - 1) @(posedge i_clk);
        end
    end

    // Watchdog: ends the run when no word moves on any channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Offer one input word, after an occasional idle burst, and wait for its acceptance.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [15:0] accel_g,
                             input logic [31:0] stamp_us, input logic [31:0] meas_alt);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {meas_alt, stamp_us, accel_g};
        s_axis_tuser <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop offering words and wait until every predicted result has been delivered.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    // Write all three gains back to back, optionally touching the spare index too.
    task automatic program_gains(input logic [GAIN_W-1:0] baro, input logic [GAIN_W-1:0] bias,
                                 input logic [GAIN_W-1:0] gps, input bit touch_spare);
        logic [CFG_IDX_W-1:0] idx[4];
        logic [GAIN_W-1:0]    val[4];
        int                   count;
        idx[0] = CFG_BARO_GAIN;
        val[0] = baro;
        idx[1] = CFG_BIAS_GAIN;
        val[1] = bias;
        idx[2] = CFG_GPS_GAIN;
        val[2] = gps;
        idx[3] = CFG_SPARE;
        val[3] = GAIN_W'($urandom);
        count = touch_spare ? 4 : 3;
        for (int k = 0; k < count; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly plausible sensor traffic around a wandering altitude, with some pure noise.
    task automatic send_random_word();
        int          pick;
        int          step_us;
        logic [CMD_W-1:0] cmd;
        logic [15:0] accel_g;
        logic [31:0] stamp_us;
        logic [31:0] meas_alt;
        pick = $urandom_range(0, 99);
        accel_g = 16'($urandom);
        stamp_us = $urandom;
        meas_alt = $urandom;
        sensor_alt = sensor_alt + int'($urandom_range(0, 4000)) - 2000;
        if (pick < 8) begin
            cmd = CMD_W'($urandom_range(0, 3));
        end else if (pick < 60) begin
            cmd = CMD_ACCEL;
            accel_g = 16'(4096 + int'($urandom_range(0, 1600)) - 800);
            case ($urandom_range(0, 19))
                0:       step_us = 0;
                1:       step_us = $urandom_range(100001, 1000000);
                2:       step_us = 100000;
                default: step_us = $urandom_range(1, 20000);
            endcase
            sensor_clock_us = sensor_clock_us + 32'(step_us);
            stamp_us = sensor_clock_us;
        end else if (pick < 85) begin
            cmd = CMD_BARO;
            meas_alt = 32'(sensor_alt + int'($urandom_range(0, 131072)) - 65536);
        end else if (pick < 95) begin
            cmd = CMD_GPS;
            meas_alt = 32'(sensor_alt + int'($urandom_range(0, 65536)) - 32768);
        end else begin
            cmd = CMD_SPARE;
        end
        send_word(cmd, accel_g, stamp_us, meas_alt);
    endtask

    // Main sequence: reset, directed words, gain phases of random words, verdict.
    initial begin : stimulus
        logic [GAIN_W-1:0] g_baro;
        logic [GAIN_W-1:0] g_bias;
        logic [GAIN_W-1:0] g_gps;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        sensor_clock_us = '0;
        sensor_alt = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Gains at their reset value: spare command, accel with no elapsed time, idle baro,
        // then the first fix anchoring at the top of the range.
        send_word(CMD_SPARE, 16'($urandom), $urandom, $urandom);
        send_word(CMD_ACCEL, 16'h1000, 32'h0000_0000, $urandom);
        send_word(CMD_BARO, 16'($urandom), $urandom, 32'h0050_0000);
        send_word(CMD_GPS, 16'($urandom), $urandom, 32'h7FFF_FFFF);
        wait_for_results();
        program_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);

        // Full gains: saturating corrections and the elapsed-time corner cases.
        send_word(CMD_GPS, 16'($urandom), $urandom, 32'h8000_0000);
        send_word(CMD_BARO, 16'($urandom), $urandom, 32'h7FFF_FFFF);
        send_word(CMD_BARO, 16'($urandom), $urandom, 32'h8000_0000);
        send_word(CMD_ACCEL, 16'h7FFF, 32'd100000, $urandom);
        send_word(CMD_ACCEL, 16'h8000, 32'd200001, $urandom);
        send_word(CMD_ACCEL, 16'h0000, 32'd200001, $urandom);
        send_word(CMD_ACCEL, 16'h1000, 32'hFFFF_FFFF, $urandom);
        send_word(CMD_ACCEL, 16'h1000, 32'h0000_0063, $urandom);
        send_word(CMD_ACCEL, 16'hF000, 32'h0000_0064, $urandom);
        send_word(CMD_GPS, 16'($urandom), $urandom, 32'h0000_0000);
        send_word(CMD_SPARE, 16'($urandom), $urandom, $urandom);
        send_word(CMD_BARO, 16'($urandom), $urandom, 32'h0000_0000);

        // Random phases, each under its own gain setting.
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_for_results();
            case (phase)
                0: begin
                    g_baro = 16'h0000;
                    g_bias = 16'h0000;
                    g_gps = 16'h0000;
                end
                1: begin
                    g_baro = 16'hFFFF;
                    g_bias = 16'hFFFF;
                    g_gps = 16'hFFFF;
                end
                2: begin
                    g_baro = 16'd6554;
                    g_bias = 16'd66;
                    g_gps = 16'd655;
                end
                4: begin
                    g_baro = 16'hFFFF;
                    g_bias = 16'h0000;
                    g_gps = GAIN_W'($urandom);
                end
                5: begin
                    g_baro = GAIN_W'($urandom_range(0, 8000));
                    g_bias = GAIN_W'($urandom_range(0, 8000));
                    g_gps = GAIN_W'($urandom_range(0, 8000));
                end
                default: begin
                    g_baro = GAIN_W'($urandom);
                    g_bias = GAIN_W'($urandom);
                    g_gps = GAIN_W'($urandom);
                end
            endcase
            program_gains(g_baro, g_bias, g_gps, phase == 3);
            sensor_clock_us = $urandom;
            sensor_alt = int'($urandom_range(0, 20000000)) - 10000000;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                no_idle = (phase == 4 && n < 60) ||
                          (phase == PHASES - 1 && n >= PHASE_WORDS - TAIL_WORDS);
                // Back up the block once by holding off the result side for a long stretch.
                if (phase == 2 && n == 40) begin
                    hold_output = 1'b1;
                end
                send_random_word();
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
